// File: src/mjpdtc_pkg.sv
`timescale 1ns / 1ps

package mjpdtc_pkg;

	localparam int TABLE_SIZE = 38;
	localparam int JNT_W      = 6;
	localparam int POS_W      = 32;
	localparam int TRQ_W      = 27;
	localparam int KP_W       = 17;
	localparam int KD_W       = 9;
	localparam int INV_W      = 17;
	localparam int LIM_W      = 10;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_INV_TIME_STEP = 2'd0;
	localparam reg_idx_t REG_TORQUE_LIMIT  = 2'd1;
	localparam reg_idx_t REG_SKIPPED_JOINT = 2'd2;

	localparam logic [INV_W-1:0] INV_TIME_STEP_RST = 17'd1000;
	localparam logic [LIM_W-1:0] TORQUE_LIMIT_RST  = 10'd500;
	localparam logic [JNT_W-1:0] SKIPPED_JOINT_RST = 6'd37;

	localparam logic [KP_W-1:0] KP_TABLE [TABLE_SIZE] = '{
		17'd33000, 17'd83000, 17'd33000, 17'd33000, 17'd47000, 17'd33000,
		17'd33000, 17'd83000, 17'd33000, 17'd33000, 17'd47000, 17'd33000,
		17'd83000, 17'd83000, 17'd83000, 17'd10000, 17'd10000, 17'd20000,
		17'd20000, 17'd20000, 17'd20000, 17'd20000, 17'd20000, 17'd20000,
		17'd20000, 17'd20000, 17'd20000, 17'd20000, 17'd20000, 17'd20000,
		17'd20000, 17'd20000, 17'd20000, 17'd400,   17'd400,   17'd400,
		17'd400,   17'd100
	};

	localparam logic [KD_W-1:0] KD_TABLE [TABLE_SIZE] = '{
		9'd240, 9'd240, 9'd240, 9'd240, 9'd240, 9'd240,
		9'd240, 9'd240, 9'd240, 9'd240, 9'd240, 9'd240,
		9'd240, 9'd240, 9'd240, 9'd200, 9'd200, 9'd320,
		9'd320, 9'd320, 9'd320, 9'd320, 9'd320, 9'd320,
		9'd320, 9'd320, 9'd320, 9'd320, 9'd320, 9'd320,
		9'd320, 9'd320, 9'd320, 9'd10,  9'd10,  9'd10,
		9'd10,  9'd5
	};

	function automatic logic [KP_W-1:0] kp_of(input logic [JNT_W-1:0] j);
		logic [KP_W-1:0] v;
		v = '0;
		if (j < JNT_W'(TABLE_SIZE)) begin
			v = KP_TABLE[j];
		end
		return v;
	endfunction

	function automatic logic [KD_W-1:0] kd_of(input logic [JNT_W-1:0] j);
		logic [KD_W-1:0] v;
		v = '0;
		if (j < JNT_W'(TABLE_SIZE)) begin
			v = KD_TABLE[j];
		end
		return v;
	endfunction

endpackage

// File: src/multi_joint_pd_torque_controller.sv
`timescale 1ns / 1ps
// Pipeline: an accepted control word passes registers s1 to s5 and the output register.
// Throughput: one word per cycle unless the output stalls; the joint state memories
// are read and written at accept and gain products run through a multiply pipeline.
// Reset: arst_n clears the pipeline valids and loads the register reset values;
// the position memories hold no defined content until each joint is captured.

module multi_joint_pd_torque_controller #(
	parameter int NUM_JOINTS = 38
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: joint_index[5:0], measured_position[37:6], zero pad.
	input  logic [39:0] s_axis_tdata,
	// Fields from bit 0: action.
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Fields from bit 0: out_joint[5:0], torque[32:6], zero pad.
	output logic [39:0] m_axis_tdata,
	// Fields from bit 0: saturated.
	output logic        m_axis_tuser
);

	localparam int JW   = mjpdtc_pkg::JNT_W;
	localparam int PW   = mjpdtc_pkg::POS_W;
	localparam int AW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int EW   = PW + 1;
	localparam int P1W  = EW + mjpdtc_pkg::KP_W + 1;
	localparam int VW   = EW + mjpdtc_pkg::INV_W + 1;
	localparam int UW   = VW + mjpdtc_pkg::KD_W + 1;

	logic [mjpdtc_pkg::INV_W-1:0] inv_q;
	logic [mjpdtc_pkg::LIM_W-1:0] lim_q;
	logic [JW-1:0]                skip_q;

	logic                         cfg_we;
	mjpdtc_pkg::reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q  <= mjpdtc_pkg::INV_TIME_STEP_RST;
			lim_q  <= mjpdtc_pkg::TORQUE_LIMIT_RST;
			skip_q <= mjpdtc_pkg::SKIPPED_JOINT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mjpdtc_pkg::REG_INV_TIME_STEP: inv_q  <= pwdata[mjpdtc_pkg::INV_W-1:0];
				mjpdtc_pkg::REG_TORQUE_LIMIT:  lim_q  <= pwdata[mjpdtc_pkg::LIM_W-1:0];
				mjpdtc_pkg::REG_SKIPPED_JOINT: skip_q <= pwdata[JW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			mjpdtc_pkg::REG_INV_TIME_STEP: prdata = {15'b0, inv_q};
			mjpdtc_pkg::REG_TORQUE_LIMIT:  prdata = {22'b0, lim_q};
			mjpdtc_pkg::REG_SKIPPED_JOINT: prdata = {26'b0, skip_q};
			default:                       prdata = '0;
		endcase
	end

	logic          en;
	logic          accept;
	logic          act;
	logic [JW-1:0] jnt;
	logic [PW-1:0] pos;
	logic          in_rng;
	logic          cap;
	logic          ctl;

	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid & en;
	assign act           = s_axis_tuser;
	assign jnt           = s_axis_tdata[JW-1:0];
	assign pos           = s_axis_tdata[JW+PW-1:JW];
	assign in_rng        = jnt < JW'(NUM_JOINTS);
	assign cap           = accept & ~act & in_rng;
	assign ctl           = accept & act & in_rng & (jnt != skip_q);

	logic [PW-1:0] ref_rd;
	logic [PW-1:0] prev_rd;

	mjpdtc_ram #(.WIDTH(PW), .DEPTH(NUM_JOINTS)) u_ref_ram (
		.clk   (clk),
		.we    (cap),
		.waddr (jnt[AW-1:0]),
		.wdata (pos),
		.re    (ctl),
		.raddr (jnt[AW-1:0]),
		.rdata (ref_rd)
	);

	mjpdtc_ram #(.WIDTH(PW), .DEPTH(NUM_JOINTS)) u_prev_ram (
		.clk   (clk),
		.we    (cap | ctl),
		.waddr (jnt[AW-1:0]),
		.wdata (pos),
		.re    (ctl),
		.raddr (jnt[AW-1:0]),
		.rdata (prev_rd)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [JW-1:0]        jnt_s1, jnt_s2, jnt_s3, jnt_s4, jnt_s5;
	logic [PW-1:0]        pos_s1;
	logic signed [EW-1:0] err_s2, dpos_s2;
	logic [mjpdtc_pkg::KP_W-1:0] kp_s2;
	logic [mjpdtc_pkg::KD_W-1:0] kd_s2, kd_s3;
	logic signed [P1W-1:0] ptrm_s3, ptrm_s4;
	logic signed [VW-1:0]  vel_s3;
	logic signed [UW-1:0]  dtrm_s4;
	logic signed [UW-1:0]  u_s5;

	logic signed [EW-1:0]  err;
	logic signed [EW-1:0]  dpos;
	logic signed [P1W-1:0] ptrm;
	logic signed [VW-1:0]  vel;
	logic signed [UW-1:0]  dtrm;
	logic signed [UW-1:0]  u;
	logic signed [UW-1:0]  lim;
	logic [mjpdtc_pkg::TRQ_W-1:0] lim_trq;
	logic [mjpdtc_pkg::TRQ_W-1:0] trq;
	logic                  sat;

	logic                         vld_q;
	logic [JW-1:0]                out_jnt_q;
	logic [mjpdtc_pkg::TRQ_W-1:0] trq_q;
	logic                         sat_q;

	assign err  = signed'({ref_rd[PW-1], ref_rd}) - signed'({pos_s1[PW-1], pos_s1});
	assign dpos = signed'({pos_s1[PW-1], pos_s1}) - signed'({prev_rd[PW-1], prev_rd});
	assign ptrm = err_s2 * signed'({1'b0, kp_s2});
	assign vel  = dpos_s2 * signed'({1'b0, inv_q});
	assign dtrm = vel_s3 * signed'({1'b0, kd_s3});
	assign u    = signed'({{(UW-P1W){ptrm_s4[P1W-1]}}, ptrm_s4}) - dtrm_s4;

	assign lim     = signed'({{(UW-mjpdtc_pkg::LIM_W-28){1'b0}}, lim_q, 28'b0});
	assign lim_trq = {1'b0, lim_q, 16'b0};

	always_comb begin
		priority if (u_s5 > lim) begin
			trq = lim_trq;
			sat = 1'b1;
		end else if (u_s5 < -lim) begin
			trq = -lim_trq;
			sat = 1'b1;
		end else begin
			trq = u_s5[mjpdtc_pkg::TRQ_W+11:12];
			sat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			v_s1  <= ctl;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			vld_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jnt_s1    <= jnt;
			pos_s1    <= pos;
			jnt_s2    <= jnt_s1;
			err_s2    <= err;
			dpos_s2   <= dpos;
			kp_s2     <= mjpdtc_pkg::kp_of(jnt_s1);
			kd_s2     <= mjpdtc_pkg::kd_of(jnt_s1);
			jnt_s3    <= jnt_s2;
			ptrm_s3   <= ptrm;
			vel_s3    <= vel;
			kd_s3     <= kd_s2;
			jnt_s4    <= jnt_s3;
			ptrm_s4   <= ptrm_s3;
			dtrm_s4   <= dtrm;
			jnt_s5    <= jnt_s4;
			u_s5      <= u;
			out_jnt_q <= jnt_s5;
			trq_q     <= trq;
			sat_q     <= sat;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {7'b0, trq_q, out_jnt_q};
	assign m_axis_tuser  = sat_q;

endmodule

// File: src/mjpdtc_ram.sv
`timescale 1ns / 1ps

module mjpdtc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 38,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/mjpdtc_checker.sv
`timescale 1ns / 1ps

module mjpdtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [39:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side can move");

	a_sat_whole: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:6] == 16'd0)
		else $error("saturated torque is not a whole newton-metre value");

endmodule

bind multi_joint_pd_torque_controller mjpdtc_checker u_mjpdtc_checker (.*);
